FILE: sv/idt_pkg.sv
`timescale 1ns / 1ps

package idt_pkg;

    // Command codes carried in the cmd field of a request.
    typedef enum logic [2:0] {
        CMD_BOUNDARY   = 3'd0,
        CMD_ADVANCE    = 3'd1,
        CMD_WRITE      = 3'd2,
        CMD_READ       = 3'd3,
        CMD_RAISE      = 3'd4,
        CMD_DELAYED_EN = 3'd5,
        CMD_SET_EN     = 3'd6,
        CMD_HALT       = 3'd7
    } t_cmd;

    // Register select codes; codes 6 and 7 address nothing.
    typedef enum logic [2:0] {
        SEL_ENABLE_MASK = 3'd0,
        SEL_REQ_FLAGS   = 3'd1,
        SEL_CONTROL     = 3'd2,
        SEL_MODULO      = 3'd3,
        SEL_COUNTER     = 3'd4,
        SEL_DIVIDER     = 3'd5
    } t_reg_sel;

    // Master interrupt enable.
    typedef enum logic [1:0] {
        IME_OFF     = 2'd0,
        IME_PENDING = 2'd1,
        IME_ON      = 2'd2
    } t_ime_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] pc;
        logic [7:0]  cycles;
        logic        end_instr;
        logic [2:0]  reg_sel;
        logic [7:0]  wdata;
        logic [4:0]  irq_bits;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        dispatch;
        logic [6:0]  vector;
        logic [15:0] push_pc;
        logic [4:0]  cycles_used;
        logic        halted;
        logic        ime_on;
    } t_rsp;

    localparam int unsigned PERIOD_W    = 11;
    localparam int unsigned TIMER_EN    = 2;
    localparam logic [4:0]  DISPATCH_COST = 5'd20;
    localparam logic [4:0]  HALT_COST     = 5'd4;
    localparam logic [6:0]  VECTOR_BASE   = 7'h40;
    localparam logic [7:0]  TIMER_IRQ     = 8'h04;

    // Prescaler period selected by the low two control bits.
    function automatic logic [PERIOD_W-1:0] period_of(input logic [1:0] sel);
        logic [PERIOD_W-1:0] p;
        case (sel)
            2'd0:    p = 11'd1024;
            2'd1:    p = 11'd16;
            2'd2:    p = 11'd64;
            default: p = 11'd256;
        endcase
        return p;
    endfunction

    // Index of the lowest set request bit; bit 4 when bits 0..3 are clear.
    function automatic logic [2:0] lowest_bit(input logic [4:0] pend);
        logic [2:0] b;
        if (pend[0]) begin
            b = 3'd0;
        end else if (pend[1]) begin
            b = 3'd1;
        end else if (pend[2]) begin
            b = 3'd2;
        end else if (pend[3]) begin
            b = 3'd3;
        end else begin
            b = 3'd4;
        end
        return b;
    endfunction

endpackage

FILE: sv/idt_cmd_if.sv
`timescale 1ns / 1ps

interface idt_cmd_if import idt_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/idt_rsp_if.sv
`timescale 1ns / 1ps

interface idt_rsp_if import idt_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/interrupt_dispatch_and_timer_top.sv
// A request accepted is held in the input register; its result is then computed
// and stored in the result register once that register is free or drains.
// Throughput: one request per cycle while results are taken; the single update stage
// that reads and writes the controller state is the only loop.
// Reset (i_rst_n low, synchronous): empty both stages, clear the control and state
// registers (not the payload registers), master enable off, not halted.
`timescale 1ns / 1ps

module interrupt_dispatch_and_timer_top import idt_pkg::*; #(
    parameter int unsigned ACC_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    idt_cmd_if.sink     i_cmd,
    idt_rsp_if.source   o_rsp
);

    // Pipeline control: the input register and the result register.
    logic       r_in_valid;
    t_req       r_req;
    logic       r_out_valid;
    t_rsp       r_rsp;
    t_rsp       n_rsp;
    logic       w_fire;
    logic       w_in_accept;

    // Controller state.
    logic [7:0]           r_mask,  n_mask;
    logic [7:0]           r_flags, n_flags;
    logic [2:0]           r_ctrl,  n_ctrl;
    logic [7:0]           r_mod,   n_mod;
    logic [7:0]           r_cnt,   n_cnt;
    logic [7:0]           r_div,   n_div;
    logic [ACC_WIDTH-1:0] r_acc,   n_acc;
    t_ime_state           r_ime,   n_ime;
    logic                 r_halt,  n_halt;

    // Shared decode of the request held in the input register.
    logic                 w_bnd;
    logic [4:0]           w_pend;
    logic                 w_pend_any;
    logic [2:0]           w_bit;
    logic                 w_take;
    logic                 w_halt_after;
    logic [4:0]           w_cost;
    logic                 w_adv_en;
    logic [7:0]           w_adv_amt;
    logic [ACC_WIDTH-1:0] w_acc_sum;
    logic [PERIOD_W-1:0]  w_period;
    logic                 w_tick;
    logic [ACC_WIDTH-1:0] w_acc_tick;
    logic [7:0]           w_cnt_inc;
    logic                 w_wrap;
    logic [7:0]           w_rd;

    // Process the held request when the result register is free or drains now.
    assign w_fire      = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_cmd.ready = !r_in_valid || w_fire;
    assign w_in_accept = i_cmd.valid && i_cmd.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // Only request bits 0..4 take part in dispatch; the upper flags just store.
    assign w_bnd        = (t_cmd'(r_req.cmd) == CMD_BOUNDARY);
    assign w_pend       = r_flags[4:0] & r_mask[4:0];
    assign w_pend_any   = |w_pend;
    assign w_bit        = lowest_bit(w_pend);
    assign w_take       = w_pend_any && (r_ime == IME_ON);
    // Any pending request wakes the block; a halted boundary then ticks the timer.
    assign w_halt_after = w_pend_any ? 1'b0 : r_halt;
    assign w_cost       = (w_take ? DISPATCH_COST : 5'd0)
                        + (w_halt_after ? HALT_COST : 5'd0);

    // Timer advance: a halted boundary or an explicit advance command.
    assign w_adv_en   = (w_bnd && w_halt_after) || (t_cmd'(r_req.cmd) == CMD_ADVANCE);
    assign w_adv_amt  = w_bnd ? {3'd0, w_cost} : r_req.cycles;
    assign w_acc_sum  = r_acc + ACC_WIDTH'(w_adv_amt);
    assign w_period   = period_of(r_ctrl[1:0]);
    // Strictly greater than the period, and at most one count per advance.
    assign w_tick     = r_ctrl[TIMER_EN] && (w_acc_sum > ACC_WIDTH'(w_period));
    assign w_acc_tick = w_acc_sum & ACC_WIDTH'(w_period - 11'd1);
    assign w_cnt_inc  = r_cnt + 8'd1;
    assign w_wrap     = (w_cnt_inc == 8'd0);

    // Register read mux; unknown selects read zero.
    always_comb begin
        case (t_reg_sel'(r_req.reg_sel))
            SEL_ENABLE_MASK: w_rd = r_mask;
            SEL_REQ_FLAGS:   w_rd = r_flags;
            SEL_CONTROL:     w_rd = {5'd0, r_ctrl};
            SEL_MODULO:      w_rd = r_mod;
            SEL_COUNTER:     w_rd = r_cnt;
            SEL_DIVIDER:     w_rd = r_div;
            default:         w_rd = 8'd0;
        endcase
    end

    // Next state of the controller for the held request.
    always_comb begin
        n_mask  = r_mask;
        n_flags = r_flags;
        n_ctrl  = r_ctrl;
        n_mod   = r_mod;
        n_cnt   = r_cnt;
        n_div   = r_div;
        n_acc   = r_acc;
        n_ime   = r_ime;
        n_halt  = r_halt;

        case (t_cmd'(r_req.cmd))
            CMD_BOUNDARY: begin
                n_halt = w_halt_after;
                if (w_take) begin
                    // Drop the master enable and clear the request being served.
                    n_ime   = IME_OFF;
                    n_flags = r_flags & ~(8'd1 << w_bit);
                end
            end
            CMD_ADVANCE: begin
                if (r_req.end_instr && (r_ime == IME_PENDING)) begin
                    n_ime = IME_ON;
                end
            end
            CMD_WRITE: begin
                case (t_reg_sel'(r_req.reg_sel))
                    SEL_ENABLE_MASK: n_mask  = r_req.wdata;
                    SEL_REQ_FLAGS:   n_flags = r_req.wdata;
                    SEL_CONTROL:     n_ctrl  = r_req.wdata[2:0];
                    SEL_MODULO:      n_mod   = r_req.wdata;
                    SEL_COUNTER:     n_cnt   = r_req.wdata;
                    SEL_DIVIDER:     n_div   = r_req.wdata;
                    default: ;
                endcase
            end
            CMD_RAISE: begin
                n_flags = r_flags | {3'd0, r_req.irq_bits};
            end
            CMD_DELAYED_EN: begin
                if (r_ime == IME_OFF) begin
                    n_ime = IME_PENDING;
                end
            end
            CMD_SET_EN: begin
                n_ime = r_req.wdata[0] ? IME_ON : IME_OFF;
            end
            CMD_HALT: begin
                n_halt = 1'b1;
            end
            default: ;
        endcase

        if (w_adv_en) begin
            n_acc = w_acc_sum;
            n_div = r_div + w_adv_amt;
            if (w_tick) begin
                n_acc = w_acc_tick;
                if (w_wrap) begin
                    // Overflow: reload from modulo and raise the timer request.
                    n_cnt   = r_mod;
                    n_flags = n_flags | TIMER_IRQ;
                end else begin
                    n_cnt = w_cnt_inc;
                end
            end
        end
    end

    // Result fields for the held request.
    always_comb begin
        n_rsp             = '0;
        n_rsp.read_data   = (t_cmd'(r_req.cmd) == CMD_READ) ? w_rd : 8'd0;
        n_rsp.dispatch    = w_bnd && w_take;
        n_rsp.vector      = (w_bnd && w_take) ? (VECTOR_BASE + {1'b0, w_bit, 3'b000})
                                              : 7'd0;
        n_rsp.push_pc     = (w_bnd && w_take) ? r_req.pc : 16'd0;
        n_rsp.cycles_used = w_bnd ? w_cost : 5'd0;
        n_rsp.halted      = n_halt;
        n_rsp.ime_on      = (n_ime == IME_ON);
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mask      <= 8'd0;
            r_flags     <= 8'd0;
            r_ctrl      <= 3'd0;
            r_mod       <= 8'd0;
            r_cnt       <= 8'd0;
            r_div       <= 8'd0;
            r_acc       <= '0;
            r_ime       <= IME_OFF;
            r_halt      <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end

            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_fire) begin
                r_mask  <= n_mask;
                r_flags <= n_flags;
                r_ctrl  <= n_ctrl;
                r_mod   <= n_mod;
                r_cnt   <= n_cnt;
                r_div   <= n_div;
                r_acc   <= n_acc;
                r_ime   <= n_ime;
                r_halt  <= n_halt;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_req <= i_cmd.data;
        end
        if (w_fire) begin
            r_rsp <= n_rsp;
        end
    end

endmodule

FILE: sv/idt_checker.sv
`timescale 1ns / 1ps

module idt_checker import idt_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_rsp i_out_data
);

    // A result that waits holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result changed while stalled");

    // A dispatch drops the enable, wakes the block and costs the dispatch.
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.dispatch) |->
        (!i_out_data.ime_on && !i_out_data.halted
         && (i_out_data.cycles_used == DISPATCH_COST)
         && (i_out_data.read_data == 8'd0)
         && ((i_out_data.vector == 7'h40) || (i_out_data.vector == 7'h48)
             || (i_out_data.vector == 7'h50) || (i_out_data.vector == 7'h58)
             || (i_out_data.vector == 7'h60))))
        else $error("inconsistent dispatch result");

    // Without dispatch there is no vector and no pushed pc.
    a_no_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data.dispatch) |->
        ((i_out_data.vector == 7'd0) && (i_out_data.push_pc == 16'd0)))
        else $error("vector or pc without dispatch");

    // A boundary that only pays the halt cost leaves the block halted.
    a_halt_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data.dispatch) |->
        (((i_out_data.cycles_used == 5'd0)
          || ((i_out_data.cycles_used == HALT_COST) && i_out_data.halted))))
        else $error("bad boundary cost");

endmodule

bind interrupt_dispatch_and_timer_top idt_checker u_idt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data)
);
